FILE: hw/rtl/hpt_pkg.sv
// Package: shared types and codes of the hashed procedure table.
`default_nettype none
package hpt_pkg;

  localparam int unsigned HASH_W = 32;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned OWNER_W = 8;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned ARGC_W = 8;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_EXPORT = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_REMOVE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_OTHER     = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_TOO_LONG  = 3'd4
  } status_e;

endpackage
`default_nettype wire

FILE: hw/rtl/hpt_if.sv
// Interfaces: command word channel and result word channel.
`default_nettype none
interface hpt_in_if;
  logic                                 valid;
  logic                                 ready;
  hpt_pkg::action_e                     action;
  logic [hpt_pkg::CHAR_W-1:0]           char_code;
  logic [hpt_pkg::OWNER_W-1:0]          program_id;
  logic signed [hpt_pkg::ADDR_W-1:0]    in_address;
  logic [hpt_pkg::ARGC_W-1:0]           in_argument_count;

  modport source (output valid, action, char_code, program_id, in_address,
                  in_argument_count, input ready);
  modport sink (input valid, action, char_code, program_id, in_address,
                in_argument_count, output ready);
endinterface

interface hpt_out_if;
  logic                                 valid;
  logic                                 ready;
  hpt_pkg::status_e                     status;
  logic [hpt_pkg::OWNER_W-1:0]          out_program_id;
  logic signed [hpt_pkg::ADDR_W-1:0]    out_address;
  logic [hpt_pkg::ARGC_W-1:0]           out_argument_count;

  modport source (output valid, status, out_program_id, out_address,
                  out_argument_count, input ready);
  modport sink (input valid, status, out_program_id, out_address,
                out_argument_count, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/hpt_mod.sv
// Fold reduction of the 32-bit name hash modulo the table size.
`default_nettype none
module hpt_mod #(
  parameter int unsigned TABLE_SIZE = 1013
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  input  wire logic [hpt_pkg::HASH_W-1:0]           hash_i,
  output      logic                                 done_o,
  output      logic [$clog2(TABLE_SIZE)-1:0]        rem_o
);
  import hpt_pkg::*;

  localparam int unsigned IDX_W  = $clog2(TABLE_SIZE);
  // residue of 2^IDX_W modulo the table size
  localparam int unsigned FOLD_K = (1 << IDX_W) - TABLE_SIZE;

  logic [HASH_W-1:0] val_q;
  logic [HASH_W-1:0] fold;
  logic [IDX_W:0]    low_ext;
  logic              fits;
  logic [IDX_W-1:0]  rem_q;
  logic              busy_q;
  logic              done_q;

  // high part weighted by 2^IDX_W mod size plus low part: same residue, strictly smaller
  assign fold    = (val_q >> IDX_W) * HASH_W'(FOLD_K) + HASH_W'(val_q[IDX_W-1:0]);
  assign fits    = (val_q[HASH_W-1:IDX_W] == '0);
  assign low_ext = {1'b0, val_q[IDX_W-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && fits) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // fold until the value fits the index width, then one conditional subtract
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= hash_i;
    end else if (busy_q && !fits) begin
      val_q <= fold;
    end
    if (busy_q && fits) begin
      rem_q <= (low_ext >= (IDX_W+1)'(TABLE_SIZE)) ?
               IDX_W'(low_ext - (IDX_W+1)'(TABLE_SIZE)) : val_q[IDX_W-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

FILE: hw/rtl/hashed_procedure_table.sv
// Sequence: an append word extends the pending name; a find or export folds the name hash
//   modulo the table size, probes slots by PROBE_STEP and registers the result, the lookup
//   scanning up to TABLE_SIZE slots and an export's empty-slot search up to TABLE_SIZE more;
//   remove visits every slot. Words are taken only in the idle state, so one command is
//   handled at a time; a find or export with an empty or overlong name skips the scan.
// Reset: control clears at once, then a clearing pass empties every slot; no word is
//   accepted during it.
`default_nettype none
module hashed_procedure_table #(
  parameter int unsigned TABLE_SIZE = 1013,
  parameter int unsigned PROBE_STEP = 7,
  parameter int unsigned NAME_CHARS = 31
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  hpt_in_if.sink   in_i,
  hpt_out_if.source out_o
);
  import hpt_pkg::*;

  localparam int unsigned IDX_W  = $clog2(TABLE_SIZE);
  localparam int unsigned CNT_W  = $clog2(TABLE_SIZE + 1);
  localparam int unsigned LEN_W  = $clog2(NAME_CHARS + 1);
  localparam int unsigned NIDX_W = $clog2(NAME_CHARS);
  localparam int unsigned NAME_W = NAME_CHARS * CHAR_W;

  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic [OWNER_W-1:0] owner;
    logic [ADDR_W-1:0]  addr;
    logic [ARGC_W-1:0]  argc;
  } meta_t;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_MOD   = 10'b0000000100,
    S_LK_RD = 10'b0000001000,
    S_LK_CK = 10'b0000010000,
    S_EM_RD = 10'b0000100000,
    S_EM_CK = 10'b0001000000,
    S_RM_RD = 10'b0010000000,
    S_RM_CK = 10'b0100000000,
    S_RESP  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // pending name
  logic [NAME_CHARS-1:0][CHAR_W-1:0] pend_name_q;
  logic [LEN_W-1:0]  pend_len_q;
  logic              pend_long_q;
  logic [HASH_W-1:0] hash_q;
  logic [NAME_W-1:0] pend_masked;

  // command context
  action_e            cmd_q;
  logic [OWNER_W-1:0] owner_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [ARGC_W-1:0]  argc_q;
  logic [IDX_W-1:0]   idx_q, idx_d, home_q, home_d;
  logic [CNT_W-1:0]   n_q, n_d;

  // result
  status_e            res_stat_q, res_stat_d;
  logic [OWNER_W-1:0] res_owner_q, res_owner_d;
  logic [ADDR_W-1:0]  res_addr_q, res_addr_d;
  logic [ARGC_W-1:0]  res_argc_q, res_argc_d;
  logic               out_valid_q;
  status_e            out_stat_q;
  logic [OWNER_W-1:0] out_owner_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic [ARGC_W-1:0]  out_argc_q;

  // memories
  meta_t              meta_mem [TABLE_SIZE];
  logic [NAME_W-1:0]  name_mem [TABLE_SIZE];
  meta_t              meta_rd_q, meta_wdata;
  logic [NAME_W-1:0]  name_rd_q;
  logic               rd_en, meta_we, name_we;

  logic               in_acc, mod_start, mod_done;
  logic [IDX_W-1:0]   mod_rem;
  logic [IDX_W:0]     idx_step;
  logic               hit, last_probe, out_load;
  logic [CHAR_W-1:0]  fold_char;
  logic [HASH_W-1:0]  hash_next;

  hpt_mod #(.TABLE_SIZE(TABLE_SIZE)) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .hash_i  (hash_q),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_load   = (state_q == S_RESP) && (!out_valid_q || out_o.ready);

  // characters past the length read as zero
  always_comb begin
    for (int i = 0; i < NAME_CHARS; i++) begin
      pend_masked[i*CHAR_W +: CHAR_W] =
        (LEN_W'(i) < pend_len_q) ? pend_name_q[i] : '0;
    end
  end

  // case folding and hash step
  always_comb begin
    fold_char = in_i.char_code;
    if (in_i.char_code >= 8'd65 && in_i.char_code <= 8'd90) begin
      fold_char = in_i.char_code + 8'd32;
    end
    hash_next = hash_q + HASH_W'(fold_char) + (hash_q << 3) + (hash_q >> 29);
  end

  assign idx_step = {1'b0, idx_q} + (IDX_W+1)'(PROBE_STEP);
  assign last_probe = (n_q == CNT_W'(TABLE_SIZE - 1));
  assign hit = (meta_rd_q.len == pend_len_q) && (meta_rd_q.len != '0) &&
               (meta_rd_q.owner != '0) && (name_rd_q == pend_masked);

  // pending name registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_len_q  <= '0;
      pend_long_q <= 1'b0;
      hash_q      <= '0;
    end else if (in_acc && in_i.action == ACT_APPEND && in_i.char_code != '0) begin
      hash_q <= hash_next;
      if (pend_len_q < LEN_W'(NAME_CHARS)) begin
        pend_len_q <= pend_len_q + 1'b1;
      end else begin
        pend_long_q <= 1'b1;
      end
    end else if (out_load) begin
      pend_len_q  <= '0;
      pend_long_q <= 1'b0;
      hash_q      <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.action == ACT_APPEND && in_i.char_code != '0 &&
        pend_len_q < LEN_W'(NAME_CHARS)) begin
      pend_name_q[pend_len_q[NIDX_W-1:0]] <= fold_char;
    end
  end

  // command capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= in_i.action;
      owner_q <= in_i.program_id;
      addr_q  <= in_i.in_address;
      argc_q  <= in_i.in_argument_count;
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    home_d     = home_q;
    n_d        = n_q;
    res_stat_d = res_stat_q;
    res_owner_d = res_owner_q;
    res_addr_d = res_addr_q;
    res_argc_d = res_argc_q;
    rd_en      = 1'b0;
    meta_we    = 1'b0;
    name_we    = 1'b0;
    meta_wdata = '0;
    mod_start  = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        meta_we = 1'b1;
        idx_d   = idx_q + 1'b1;
        if (idx_q == IDX_W'(TABLE_SIZE - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc && in_i.action != ACT_APPEND) begin
          res_stat_d  = STAT_OK;
          res_owner_d = '0;
          res_addr_d  = '0;
          res_argc_d  = '0;
          if (in_i.action == ACT_REMOVE) begin
            idx_d   = '0;
            state_d = S_RM_RD;
          end else if (pend_long_q) begin
            res_stat_d = STAT_TOO_LONG;
            state_d    = S_RESP;
          end else if (pend_len_q == '0) begin
            res_stat_d = STAT_NOT_FOUND;
            state_d    = S_RESP;
          end else begin
            mod_start = 1'b1;
            state_d   = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          home_d  = mod_rem;
          idx_d   = mod_rem;
          n_d     = '0;
          state_d = S_LK_RD;
        end
      end
      S_LK_RD, S_EM_RD, S_RM_RD: begin
        rd_en = 1'b1;
        state_d = (state_q == S_LK_RD) ? S_LK_CK :
                  (state_q == S_EM_RD) ? S_EM_CK : S_RM_CK;
      end
      S_LK_CK: begin
        if (hit) begin
          state_d = S_RESP;
          if (cmd_q == ACT_FIND) begin
            res_owner_d = meta_rd_q.owner;
            res_addr_d  = meta_rd_q.addr;
            res_argc_d  = meta_rd_q.argc;
          end else if (meta_rd_q.owner != owner_q) begin
            res_stat_d = STAT_OTHER;
          end else begin
            meta_we    = 1'b1;
            meta_wdata = '{len: meta_rd_q.len, owner: owner_q, addr: addr_q,
                           argc: argc_q};
          end
        end else if (last_probe) begin
          if (cmd_q == ACT_FIND) begin
            res_stat_d = STAT_NOT_FOUND;
            state_d    = S_RESP;
          end else begin
            idx_d   = home_q;
            n_d     = '0;
            state_d = S_EM_RD;
          end
        end else begin
          n_d     = n_q + 1'b1;
          idx_d   = (idx_step >= (IDX_W+1)'(TABLE_SIZE)) ?
                    IDX_W'(idx_step - (IDX_W+1)'(TABLE_SIZE)) : idx_step[IDX_W-1:0];
          state_d = S_LK_RD;
        end
      end
      S_EM_CK: begin
        if (meta_rd_q.len == '0) begin
          meta_we    = 1'b1;
          name_we    = 1'b1;
          meta_wdata = '{len: pend_len_q, owner: owner_q, addr: addr_q, argc: argc_q};
          state_d    = S_RESP;
        end else if (last_probe) begin
          res_stat_d = STAT_FULL;
          state_d    = S_RESP;
        end else begin
          n_d     = n_q + 1'b1;
          idx_d   = (idx_step >= (IDX_W+1)'(TABLE_SIZE)) ?
                    IDX_W'(idx_step - (IDX_W+1)'(TABLE_SIZE)) : idx_step[IDX_W-1:0];
          state_d = S_EM_RD;
        end
      end
      S_RM_CK: begin
        if (meta_rd_q.owner == owner_q) begin
          meta_we    = 1'b1;
          meta_wdata = '{len: '0, owner: '0, addr: meta_rd_q.addr,
                         argc: meta_rd_q.argc};
        end
        idx_d = idx_q + 1'b1;
        state_d = (idx_q == IDX_W'(TABLE_SIZE - 1)) ? S_RESP : S_RM_RD;
      end
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    home_q      <= home_d;
    n_q         <= n_d;
    res_stat_q  <= res_stat_d;
    res_owner_q <= res_owner_d;
    res_addr_q  <= res_addr_d;
    res_argc_q  <= res_argc_d;
  end

  // slot record memory
  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_mem[idx_q] <= meta_wdata;
    end
    if (rd_en) begin
      meta_rd_q <= meta_mem[idx_q];
    end
  end

  // slot name memory
  always_ff @(posedge clk_i) begin
    if (name_we) begin
      name_mem[idx_q] <= pend_masked;
    end
    if (rd_en) begin
      name_rd_q <= name_mem[idx_q];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_stat_q  <= res_stat_q;
      out_owner_q <= res_owner_q;
      out_addr_q  <= res_addr_q;
      out_argc_q  <= res_argc_q;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.status             = out_stat_q;
  assign out_o.out_program_id     = out_owner_q;
  assign out_o.out_address        = out_addr_q;
  assign out_o.out_argument_count = out_argc_q;

`ifndef SYNTH
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_i.ready) else $error("word accepted during clear");
  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESP)) else $error("stray result");
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_len_q <= LEN_W'(NAME_CHARS)) else $error("pending length overflow");
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meta_we |-> (state_q == S_CLEAR || state_q == S_LK_CK ||
                 state_q == S_EM_CK || state_q == S_RM_CK))
    else $error("slot write outside check state");
`endif

endmodule
`default_nettype wire
